FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, reset on rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication property, disabled during reset
`define PRG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("port property violated");

// plain invariant, disabled during reset
`define PRG_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("port invariant violated");

`endif

FILE: rtl/prg_pkg.sv
// ----------------------------------------------------------------------------
// prg_pkg
// Shared widths, types and register codes of the primary ray generator.
// ----------------------------------------------------------------------------
package prg_pkg;

  localparam int MAX_DIM_DEF   = 4096;
  localparam int COEF_BITS_DEF = 16;

  localparam int PIX_W   = 12;
  localparam int DIM_W   = 13;
  localparam int FOC_W   = 16;
  localparam int POS_W   = 60;
  localparam int VW      = 30;
  localparam int AN_W    = 30;
  localparam int NORM_MSB = AN_W - 1;
  localparam int SQ_W    = 2 * AN_W;
  localparam int RAD_W   = SQ_W + 2;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int SQRT_LAT = ROOT_W;
  localparam int DIR_FRAC = 14;
  localparam int DIR_W   = 16;
  localparam int QUO_W   = DIR_FRAC + 1;
  localparam int NUM_W   = AN_W + QUO_W;
  localparam int DIV_LAT = QUO_W;
  localparam int FIFO_DEPTH = 4;

  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_FOCAL  = 3'd2,
    REG_ROW0   = 3'd3,
    REG_ROW1   = 3'd4,
    REG_ROW2   = 3'd5,
    REG_POS    = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [FOC_W-1:0] focal;
  } cam_cfg_t;

  typedef struct packed {
    logic signed [VW-1:0] vz;
    logic signed [VW-1:0] vy;
    logic signed [VW-1:0] vx;
  } ray_vec_t;

endpackage

FILE: rtl/pinhole_primary_ray_generator_unit.sv
// ----------------------------------------------------------------------------
// pinhole_primary_ray_generator_unit
// Pinhole camera primary ray generator: pixel in, origin and unit direction out.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one pixel word (x, y); master stream returns one ray
//   word per pixel, in order. An APB port loads image size, focal length,
//   the three rotation rows and the camera position; write only while idle.
//   The front part computes the camera vector and pushes it into a 4-entry
//   queue; the back part is a fully pipelined datapath: matrix products,
//   sum, magnitude, max, leading-one search, normalize shift, squares, norm
//   sum, a 31-stage square root and three 15-stage dividers.
//   Throughput: one ray per cycle unless the master side stalls. The delay
//   from acceptance to tvalid comes mostly from the square root and dividers.
//   When the master side stalls, the whole back pipeline holds and the queue
//   keeps accepting until full, then tready drops.
//   Reset clears all valid state and loads the default registers (640x480,
//   focal 1.0, identity rotation, origin at zero).
// ----------------------------------------------------------------------------
module pinhole_primary_ray_generator_unit import prg_pkg::*; #(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int COEF_BITS = COEF_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [23:0]  s_axis_tdata,  // pixel_x, pixel_y
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, 4 zero bits
  output logic [111:0] m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  localparam int CB    = COEF_BITS;
  localparam int ROW_W = (3 * CB > 48) ? 3 * CB : 48;
  localparam int PW    = CB + VW;
  localparam int RW    = PW + 2;
  localparam int SW    = $clog2(RW);
  localparam int AUX_LAT = SQRT_LAT + 2;
  localparam logic [ROW_W-1:0] ONE_C = ROW_W'(1) << (CB - 2);

  // configuration
  logic [DIM_W-1:0] width_q, height_q;
  logic [FOC_W-1:0] focal_q;
  logic [ROW_W-1:0] row_q [3];
  logic [POS_W-1:0] pos_q;
  logic             wr_en;
  reg_idx_e         idx;
  cam_cfg_t         cfg;

  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
    return ({19'b0, v} > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : v;
  endfunction

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(640);
      height_q <= DIM_W'(480);
      focal_q  <= FOC_W'(256);
      row_q[0] <= ONE_C;
      row_q[1] <= ONE_C << CB;
      row_q[2] <= ONE_C << (2 * CB);
      pos_q    <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_WIDTH:  width_q  <= sat_dim(pwdata[DIM_W-1:0]);
        REG_HEIGHT: height_q <= sat_dim(pwdata[DIM_W-1:0]);
        REG_FOCAL:  focal_q  <= pwdata[FOC_W-1:0];
        REG_ROW0:   row_q[0] <= pwdata[ROW_W-1:0];
        REG_ROW1:   row_q[1] <= pwdata[ROW_W-1:0];
        REG_ROW2:   row_q[2] <= pwdata[ROW_W-1:0];
        REG_POS:    pos_q    <= pwdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_WIDTH:  prdata = 64'(width_q);
      REG_HEIGHT: prdata = 64'(height_q);
      REG_FOCAL:  prdata = 64'(focal_q);
      REG_ROW0:   prdata = 64'(row_q[0]);
      REG_ROW1:   prdata = 64'(row_q[1]);
      REG_ROW2:   prdata = 64'(row_q[2]);
      REG_POS:    prdata = 64'(pos_q);
      default:    prdata = '0;
    endcase
  end

  assign cfg.width  = width_q;
  assign cfg.height = height_q;
  assign cfg.focal  = focal_q;

  // front
  logic     en, vec_valid, pop;
  ray_vec_t vec;
  logic     m_valid_q;

  assign en  = !m_valid_q || m_axis_tready;
  assign pop = en && vec_valid;

  prg_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .pop_i         (pop),
    .vec_valid_o   (vec_valid),
    .vec_o         (vec)
  );

  // back pipeline
  logic signed [CB-1:0] coef_w [3][3];
  logic signed [VW-1:0] v_w [3];
  logic signed [PW-1:0] p_d [3][3];
  logic signed [PW-1:0] p_q [3][3];
  logic signed [RW-1:0] r_q [3];
  logic [RW-1:0]        a3_q [3], a4_q [3], a5_q [3];
  logic [2:0]           neg3_q, neg4_q, neg5_q, neg6_q;
  logic [RW-1:0]        m4_d, m4_q;
  logic [SW-1:0]        msb_d, msb5_q;
  logic                 zero5_q, zero6_q;
  logic [AN_W-1:0]      an_d [3];
  logic [AN_W-1:0]      an6_q [3];
  logic [SQ_W-1:0]      sq7_q [3];
  logic [RAD_W-1:0]     n2_q;
  logic [ROOT_W-1:0]    root;
  logic [AN_W-1:0]      aux_a_q [AUX_LAT][3];
  logic [2:0]           aux_neg_q [AUX_LAT];
  logic                 aux_zero_q [AUX_LAT];
  logic [NUM_W-1:0]     num_q [3];
  logic [ROOT_W-1:0]    den_q;
  logic [2:0]           nneg_q;
  logic                 nzero_q;
  logic [2:0]           dneg_q [DIV_LAT];
  logic                 dzero_q [DIV_LAT];
  logic [QUO_W-1:0]     quo [3];
  logic [DIR_W-1:0]     dir_q [3];
  logic [5:0]           vld_q;
  logic [AUX_LAT-1:0]   aux_v_q;
  logic                 nv_q;
  logic [DIV_LAT-1:0]   dv_q;

  always_comb begin
    v_w[0] = vec.vx;
    v_w[1] = vec.vy;
    v_w[2] = vec.vz;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        coef_w[i][k] = row_q[i][CB*k +: CB];
        p_d[i][k]    = coef_w[i][k] * v_w[k];
      end
    end
  end

  always_comb begin
    m4_d = a3_q[0];
    if (a3_q[1] > m4_d) m4_d = a3_q[1];
    if (a3_q[2] > m4_d) m4_d = a3_q[2];
  end

  always_comb begin
    msb_d = '0;
    for (int b = 0; b < RW; b++) begin
      if (m4_q[b]) msb_d = SW'(b);
    end
  end

  always_comb begin
    logic [RW-1:0] sh;
    for (int i = 0; i < 3; i++) begin
      if (msb5_q >= SW'(NORM_MSB)) sh = a5_q[i] >> (msb5_q - SW'(NORM_MSB));
      else sh = a5_q[i] << (SW'(NORM_MSB) - msb5_q);
      an_d[i] = sh[AN_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q <= p_d;
      for (int i = 0; i < 3; i++) begin
        r_q[i]  <= RW'(p_q[i][0]) + RW'(p_q[i][1]) + RW'(p_q[i][2]);
        a3_q[i] <= r_q[i][RW-1] ? RW'(-r_q[i]) : RW'(r_q[i]);
        neg3_q[i] <= r_q[i][RW-1];
        an6_q[i] <= an_d[i];
        sq7_q[i] <= an6_q[i] * an6_q[i];
      end
      a4_q    <= a3_q;
      neg4_q  <= neg3_q;
      m4_q    <= m4_d;
      a5_q    <= a4_q;
      neg5_q  <= neg4_q;
      msb5_q  <= msb_d;
      zero5_q <= (m4_q == '0);
      neg6_q  <= neg5_q;
      zero6_q <= zero5_q;
      n2_q <= RAD_W'(sq7_q[0]) + RAD_W'(sq7_q[1]) + RAD_W'(sq7_q[2]);
      aux_a_q[0]    <= an6_q;
      aux_neg_q[0]  <= neg6_q;
      aux_zero_q[0] <= zero6_q;
      for (int j = 1; j < AUX_LAT; j++) begin
        aux_a_q[j]    <= aux_a_q[j-1];
        aux_neg_q[j]  <= aux_neg_q[j-1];
        aux_zero_q[j] <= aux_zero_q[j-1];
      end
      for (int i = 0; i < 3; i++) begin
        num_q[i] <= {1'b0, aux_a_q[AUX_LAT-1][i], {DIR_FRAC{1'b0}}}
                    + NUM_W'(root[ROOT_W-1:1]);
      end
      den_q   <= root;
      nneg_q  <= aux_neg_q[AUX_LAT-1];
      nzero_q <= aux_zero_q[AUX_LAT-1];
      dneg_q[0]  <= nneg_q;
      dzero_q[0] <= nzero_q;
      for (int j = 1; j < DIV_LAT; j++) begin
        dneg_q[j]  <= dneg_q[j-1];
        dzero_q[j] <= dzero_q[j-1];
      end
      for (int i = 0; i < 3; i++) begin
        logic [DIR_W-1:0] mag;
        mag = (quo[i] > QUO_W'(1 << DIR_FRAC)) ? DIR_W'(1 << DIR_FRAC) : DIR_W'(quo[i]);
        if (dzero_q[DIV_LAT-1]) dir_q[i] <= '0;
        else if (dneg_q[DIV_LAT-1][i]) dir_q[i] <= -mag;
        else dir_q[i] <= mag;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      aux_v_q   <= '0;
      nv_q      <= 1'b0;
      dv_q      <= '0;
      m_valid_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[4:0], vec_valid};
      aux_v_q   <= {aux_v_q[AUX_LAT-2:0], vld_q[5]};
      nv_q      <= aux_v_q[AUX_LAT-1];
      dv_q      <= {dv_q[DIV_LAT-2:0], nv_q};
      m_valid_q <= dv_q[DIV_LAT-1];
    end
  end

  prg_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (n2_q),
    .root_o (root)
  );

  for (genvar g = 0; g < 3; g++) begin : g_div
    prg_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num_q[g]),
      .den_i (den_q),
      .quo_o (quo[g])
    );
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0, dir_q[2], dir_q[1], dir_q[0], pos_q};

endmodule

FILE: rtl/prg_front.sv
// ----------------------------------------------------------------------------
// prg_front
// Accepts pixel words, forms the camera-space vector and queues it.
// ----------------------------------------------------------------------------
module prg_front import prg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cam_cfg_t    cfg_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // pixel_x, pixel_y
  input  logic        pop_i,
  output logic        vec_valid_o,
  output ray_vec_t    vec_o
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  ray_vec_t           fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]     count_q;
  logic               push, pop;
  logic [PIX_W-1:0]   px, py;
  logic signed [14:0] dx, dy;
  logic [28:0]        fh;
  ray_vec_t           vec_d;

  assign px = s_axis_tdata[11:0];
  assign py = s_axis_tdata[23:12];

  always_comb begin
    dx = $signed({2'b0, px, 1'b0}) - $signed({2'b0, cfg_i.width});
    dy = $signed({2'b0, cfg_i.height}) - $signed({2'b0, py, 1'b0});
    fh = cfg_i.focal * cfg_i.height;
    vec_d.vx = {{(VW-23){dx[14]}}, dx, 8'b0};
    vec_d.vy = {{(VW-23){dy[14]}}, dy, 8'b0};
    vec_d.vz = {{(VW-29){1'b0}}, fh};
  end

  assign s_axis_tready = (count_q != (PTR_W+1)'(FIFO_DEPTH));
  assign push = s_axis_tvalid && s_axis_tready;
  assign vec_valid_o = (count_q != '0);
  assign pop = pop_i && vec_valid_o;
  assign vec_o = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop) count_q <= count_q + 1'b1;
      else if (pop && !push) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= vec_d;
  end

endmodule

FILE: rtl/prg_isqrt.sv
// ----------------------------------------------------------------------------
// prg_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module prg_isqrt import prg_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [RAD_W-1:0]  rad_i,
  output logic [ROOT_W-1:0] root_o
);

  logic [RAD_W-1:0] x_q [SQRT_LAT];
  logic [RAD_W-1:0] r_q [SQRT_LAT];
  logic [RAD_W-1:0] x_d [SQRT_LAT];
  logic [RAD_W-1:0] r_d [SQRT_LAT];

  always_comb begin
    logic [RAD_W-1:0] xin, rin, bitv, t;
    for (int s = 0; s < SQRT_LAT; s++) begin
      xin  = (s == 0) ? rad_i : x_q[(s == 0) ? 0 : s-1];
      rin  = (s == 0) ? '0 : r_q[(s == 0) ? 0 : s-1];
      bitv = RAD_W'(1) << (2 * (SQRT_LAT - 1 - s));
      t    = rin + bitv;
      if (xin >= t) begin
        x_d[s] = xin - t;
        r_d[s] = (rin >> 1) + bitv;
      end else begin
        x_d[s] = xin;
        r_d[s] = rin >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < SQRT_LAT; s++) begin
        x_q[s] <= x_d[s];
        r_q[s] <= r_d[s];
      end
    end
  end

  assign root_o = r_q[SQRT_LAT-1][ROOT_W-1:0];

endmodule

FILE: rtl/prg_div.sv
// ----------------------------------------------------------------------------
// prg_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module prg_div import prg_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [ROOT_W-1:0] den_i,
  output logic [QUO_W-1:0]  quo_o
);

  logic [ROOT_W-1:0] rem_q [DIV_LAT];
  logic [QUO_W-1:0]  lo_q  [DIV_LAT];
  logic [QUO_W-1:0]  q_q   [DIV_LAT];
  logic [ROOT_W-1:0] den_q [DIV_LAT];
  logic [ROOT_W-1:0] rem_d [DIV_LAT];
  logic [QUO_W-1:0]  lo_d  [DIV_LAT];
  logic [QUO_W-1:0]  q_d   [DIV_LAT];
  logic [ROOT_W-1:0] den_d [DIV_LAT];

  always_comb begin
    logic [ROOT_W-1:0] rin, dn;
    logic [QUO_W-1:0]  lin, qin;
    logic [ROOT_W:0]   t;
    logic              ge;
    for (int s = 0; s < DIV_LAT; s++) begin
      if (s == 0) begin
        rin = ROOT_W'(num_i[NUM_W-1:QUO_W]);
        lin = num_i[QUO_W-1:0];
        qin = '0;
        dn  = den_i;
      end else begin
        rin = rem_q[(s == 0) ? 0 : s-1];
        lin = lo_q[(s == 0) ? 0 : s-1];
        qin = q_q[(s == 0) ? 0 : s-1];
        dn  = den_q[(s == 0) ? 0 : s-1];
      end
      t  = {rin, lin[QUO_W-1]};
      ge = (t >= {1'b0, dn});
      rem_d[s] = ge ? ROOT_W'(t - {1'b0, dn}) : t[ROOT_W-1:0];
      lo_d[s]  = lin << 1;
      q_d[s]   = {qin[QUO_W-2:0], ge};
      den_d[s] = dn;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < DIV_LAT; s++) begin
        rem_q[s] <= rem_d[s];
        lo_q[s]  <= lo_d[s];
        q_q[s]   <= q_d[s];
        den_q[s] <= den_d[s];
      end
    end
  end

  assign quo_o = q_q[DIV_LAT-1];

endmodule

FILE: rtl/prg_checker.sv
// ----------------------------------------------------------------------------
// prg_checker
// Port-level checks of the ray generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prg_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [111:0] m_axis_tdata,
  input logic         pready
);

  `PRG_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
  `PRG_ASSERT(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
  `PRG_ASSERT(a_dirx_unit, m_axis_tvalid |-> ($signed(m_axis_tdata[75:60]) <= 16'sd16384 && $signed(m_axis_tdata[75:60]) >= -16'sd16384))
  `PRG_ASSERT_ALWAYS(a_pready, pready)

endmodule

bind pinhole_primary_ray_generator_unit prg_checker u_prg_checker (.*);
